FILE: hw/rtl/windowed_rate_meter_core_defines.svh
// Assertion macros shared by the windowed rate meter modules.
`ifndef WINDOWED_RATE_METER_CORE_DEFINES_SVH
`define WINDOWED_RATE_METER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define WRM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define WRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/wrm_pkg.sv
// Types, constants and helpers shared by the windowed rate meter.
package wrm_pkg;

    // Width of the time base; legal range 32 to 64.
    localparam int TIME_WIDTH = 48;
    localparam int NOW_W      = 48;
    localparam int CNT_W      = 32;
    localparam int TOT_W      = 64;
    localparam int QW         = 32;
    localparam int QCNT_W     = $clog2(QW);
    localparam int MUL_W      = 27;
    localparam int PP_W       = QW + MUL_W;
    localparam int BUSY_W     = 7;

    localparam logic [MUL_W-1:0]  RATE_SCALE = MUL_W'(100000000);
    localparam logic [MUL_W-1:0]  KBPS_SCALE = MUL_W'(8000);
    localparam logic [MUL_W-1:0]  BUSY_SCALE = MUL_W'(100);
    localparam logic [MUL_W-1:0]  UNIT_SCALE = MUL_W'(1);
    localparam logic [BUSY_W-1:0] BUSY_MAX   = BUSY_W'(100);
    localparam logic [CNT_W-1:0]  WIN_RESET  = CNT_W'(1000000);
    localparam logic [QW-1:0]     Q_SAT      = '1;

    typedef enum logic [2:0] {
        ACT_FRAME   = 3'd0,
        ACT_ENCODE  = 3'd1,
        ACT_CONVERT = 3'd2,
        ACT_SKIP    = 3'd3,
        ACT_TICK    = 3'd4,
        ACT_LOSS    = 3'd5
    } t_action;

    typedef struct packed {
        logic                  event_en;
        logic [2:0]            action;
        logic [CNT_W-1:0]      amount;
        logic                  open;
        logic                  restart;
        logic [TIME_WIDTH-1:0] now;
    } t_acc_cmd;

    typedef struct packed {
        logic                  window_open;
        logic [TIME_WIDTH-1:0] start_time;
        logic [CNT_W-1:0]      frame_count;
        logic [CNT_W-1:0]      skip_count;
        logic [TOT_W-1:0]      byte_total;
        logic [TOT_W-1:0]      enc_total;
        logic [TOT_W-1:0]      conv_total;
        logic [CNT_W-1:0]      enc_count;
    } t_acc_state;

    typedef struct packed {
        logic             start;
        logic [TOT_W-1:0] a;
        logic [MUL_W-1:0] m;
        logic [TOT_W-1:0] d;
    } t_md_req;

    typedef struct packed {
        logic          done;
        logic [QW-1:0] q;
    } t_md_rsp;

    typedef struct packed {
        logic [QW-1:0]     frames_per_sec_x100;
        logic [QW-1:0]     kilobits_per_sec;
        logic [QW-1:0]     skips_per_sec_x100;
        logic [QW-1:0]     encode_avg_us;
        logic [QW-1:0]     convert_avg_us;
        logic [BUSY_W-1:0] busy_percent;
        logic              window_closed;
    } t_result;

    function automatic logic [TIME_WIDTH-1:0] to_time(input logic [NOW_W-1:0] now);
        logic [63:0] wide;
        wide = 64'(now);
        return wide[TIME_WIDTH-1:0];
    endfunction

endpackage

FILE: hw/rtl/wrm_ifs.sv
// Handshake channel interfaces of the windowed rate meter.
interface wrm_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [31:0] amount;
    logic [47:0] now_us;

    modport source(output valid, action, amount, now_us, input ready);
    modport sink(input valid, action, amount, now_us, output ready);
endinterface

interface wrm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] frames_per_sec_x100;
    logic [31:0] kilobits_per_sec;
    logic [31:0] skips_per_sec_x100;
    logic [31:0] encode_avg_us;
    logic [31:0] convert_avg_us;
    logic [6:0]  busy_percent;
    logic        window_closed;

    modport source(output valid, frames_per_sec_x100, kilobits_per_sec, skips_per_sec_x100,
                   encode_avg_us, convert_avg_us, busy_percent, window_closed,
                   input ready);
    modport sink(input valid, frames_per_sec_x100, kilobits_per_sec, skips_per_sec_x100,
                 encode_avg_us, convert_avg_us, busy_percent, window_closed,
                 output ready);
endinterface

interface wrm_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

FILE: hw/rtl/wrm_accum.sv
// Window state and per-window accumulators of the rate meter.
module wrm_accum (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wrm_pkg::t_acc_cmd  i_cmd,
    output wrm_pkg::t_acc_state o_state
);
    import wrm_pkg::*;

    t_acc_state r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            if (i_cmd.open) begin
                r_acc.window_open <= 1'b1;
                r_acc.start_time  <= i_cmd.now;
            end
            if (i_cmd.restart) begin
                r_acc.start_time  <= i_cmd.now;
                r_acc.frame_count <= '0;
                r_acc.skip_count  <= '0;
                r_acc.byte_total  <= '0;
                r_acc.enc_total   <= '0;
                r_acc.conv_total  <= '0;
                r_acc.enc_count   <= '0;
            end
            if (i_cmd.event_en) begin
                case (i_cmd.action)
                    ACT_FRAME: begin
                        r_acc.frame_count <= r_acc.frame_count + CNT_W'(1);
                        r_acc.byte_total  <= r_acc.byte_total + TOT_W'(i_cmd.amount);
                    end
                    ACT_ENCODE: begin
                        r_acc.enc_total <= r_acc.enc_total + TOT_W'(i_cmd.amount);
                        r_acc.enc_count <= r_acc.enc_count + CNT_W'(1);
                    end
                    ACT_CONVERT: begin
                        r_acc.conv_total <= r_acc.conv_total + TOT_W'(i_cmd.amount);
                    end
                    ACT_SKIP: begin
                        r_acc.skip_count <= r_acc.skip_count + CNT_W'(1);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_state = r_acc;

endmodule

FILE: hw/rtl/wrm_muldiv.sv
// Shared multiply-then-divide unit with a 32-bit saturated quotient.
`include "windowed_rate_meter_core_defines.svh"

module wrm_muldiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wrm_pkg::t_md_req i_req,
    output wrm_pkg::t_md_rsp o_rsp
);
    import wrm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_CHK,
        S_DIV
    } t_state;

    t_state             r_state;
    logic [TOT_W-1:0]   r_a;
    logic [MUL_W-1:0]   r_m;
    logic [TOT_W-1:0]   r_d;
    logic [PP_W-1:0]    r_plo;
    logic [PP_W-1:0]    r_phi;
    logic [TOT_W-1:0]   r_rem;
    logic [QW-1:0]      r_low;
    logic [QW-1:0]      r_q;
    logic [QCNT_W-1:0]  r_cnt;
    logic               r_done;

    logic [TOT_W-1:0]   upper;
    logic [TOT_W:0]     rem2;
    logic [TOT_W:0]     diff;
    logic               ge;

    always_comb begin
        upper = TOT_W'(r_phi) + TOT_W'(r_plo[PP_W-1:QW]);
        rem2  = {r_rem, r_low[QW-1]};
        diff  = rem2 - {1'b0, r_d};
        ge    = (rem2 >= {1'b0, r_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_a     <= i_req.a;
                        r_m     <= i_req.m;
                        r_d     <= i_req.d;
                        r_state <= S_MUL_LO;
                    end
                end
                S_MUL_LO: begin
                    r_plo   <= PP_W'(r_a[QW-1:0]) * PP_W'(r_m);
                    r_state <= S_MUL_HI;
                end
                S_MUL_HI: begin
                    r_phi   <= PP_W'(r_a[TOT_W-1:QW]) * PP_W'(r_m);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (upper >= r_d) begin
                        r_q     <= Q_SAT;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_rem   <= upper;
                        r_low   <= r_plo[QW-1:0];
                        r_cnt   <= QCNT_W'(QW - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= ge ? diff[TOT_W-1:0] : rem2[TOT_W-1:0];
                    r_q   <= {r_q[QW-2:0], ge};
                    r_low <= {r_low[QW-2:0], 1'b0};
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt - QCNT_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;

    `WRM_ASSERT_NEXT(a_done_single, r_done, !r_done, "quotient strobe lasted more than one cycle")
    `WRM_ASSERT_NEXT(a_div_ends, r_state == S_DIV && r_cnt == '0, r_done, "division did not finish")
    `WRM_ASSERT_NOW(a_done_idle, r_done, r_state == S_IDLE, "quotient strobe while still busy")

endmodule

FILE: hw/rtl/windowed_rate_meter_core.sv
// Top level of the windowed rate meter: sequencer, configuration and result registers.
//
// Frame, encode, conversion and skip transactions update the accumulators directly, and a
// signal-loss transaction loads the held averages and busy share into the result to be pushed.
// A tick on an open window that does not close it keeps the input not ready while the elapsed
// time is checked against the window length. A tick that closes the window runs six jobs of
// multiply-and-divide one after another on a single shared unit that retires one quotient bit
// per cycle, with the input not ready until all are done; a job is bypassed when an average has
// no encodes or the busy share clamps, and a saturated quotient ends its job early. A finished
// result waits in its output register while the next transaction is taken; a further result
// cannot leave the sequencer until that register is free; the input stays not ready meanwhile.
`include "windowed_rate_meter_core_defines.svh"

module windowed_rate_meter_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wrm_cfg_if.sink   i_cfg,
    wrm_in_if.sink    i_in,
    wrm_out_if.source o_out
);
    import wrm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ELAPSED,
        S_CMP,
        S_LAUNCH,
        S_WAIT,
        S_CLOSE,
        S_PUSH
    } t_state;

    typedef enum logic [2:0] {
        OP_FPS,
        OP_KBPS,
        OP_SPS,
        OP_ENC,
        OP_CONV,
        OP_BUSY
    } t_op;

    t_state                r_state;
    t_op                   r_op;
    logic [CNT_W-1:0]      r_win_len;
    logic [TIME_WIDTH-1:0] r_now;
    logic [TIME_WIDTH-1:0] r_elapsed;
    logic [TOT_W:0]        r_sum;
    logic [QW-1:0]         r_held_enc;
    logic [QW-1:0]         r_held_conv;
    logic [BUSY_W-1:0]     r_held_busy;
    t_result               r_res;
    t_result               r_out;
    logic                  r_out_valid;

    t_acc_cmd              acc_cmd;
    t_acc_state            acc;
    t_md_req               md_req;
    t_md_rsp               md_rsp;

    logic                  in_acc;
    logic                  out_free;
    logic [TIME_WIDTH-1:0] in_now;
    logic [CNT_W-1:0]      limit;
    logic [TOT_W-1:0]      elapsed64;
    logic                  bypass;
    logic [QW-1:0]         bypass_val;
    logic                  op_fin;
    logic [QW-1:0]         op_val;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || o_out.ready;
    assign in_now      = to_time(i_in.now_us);
    assign limit       = (r_win_len == '0) ? CNT_W'(1) : r_win_len;
    assign elapsed64   = 64'(r_elapsed);

    always_comb begin
        acc_cmd.event_en = in_acc && (i_in.action == ACT_FRAME || i_in.action == ACT_ENCODE ||
                                      i_in.action == ACT_CONVERT || i_in.action == ACT_SKIP);
        acc_cmd.action   = i_in.action;
        acc_cmd.amount   = i_in.amount;
        acc_cmd.open     = in_acc && (i_in.action == ACT_TICK) && !acc.window_open;
        acc_cmd.restart  = (r_state == S_CLOSE);
        acc_cmd.now      = acc_cmd.open ? in_now : r_now;
    end

    always_comb begin
        md_req.a   = 64'(acc.frame_count);
        md_req.m   = RATE_SCALE;
        md_req.d   = elapsed64;
        bypass     = 1'b0;
        bypass_val = '0;
        unique case (r_op)
            OP_FPS: begin
            end
            OP_KBPS: begin
                md_req.a = acc.byte_total;
                md_req.m = KBPS_SCALE;
            end
            OP_SPS: begin
                md_req.a = 64'(acc.skip_count);
            end
            OP_ENC: begin
                md_req.a = acc.enc_total;
                md_req.m = UNIT_SCALE;
                md_req.d = 64'(acc.enc_count);
                bypass   = (acc.enc_count == '0);
            end
            OP_CONV: begin
                md_req.a = acc.conv_total;
                md_req.m = UNIT_SCALE;
                md_req.d = 64'(acc.enc_count);
                bypass   = (acc.enc_count == '0);
            end
            OP_BUSY: begin
                md_req.a   = r_sum[TOT_W-1:0];
                md_req.m   = BUSY_SCALE;
                bypass     = r_sum[TOT_W] || (r_sum[TOT_W-1:0] >= elapsed64);
                bypass_val = QW'(BUSY_MAX);
            end
            default: begin
            end
        endcase
        md_req.start = (r_state == S_LAUNCH) && !bypass;
        op_fin = ((r_state == S_LAUNCH) && bypass) || ((r_state == S_WAIT) && md_rsp.done);
        op_val = (r_state == S_WAIT) ? md_rsp.q : bypass_val;
    end

    wrm_accum u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (acc_cmd),
        .o_state (acc)
    );

    wrm_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_FPS;
            r_win_len   <= WIN_RESET;
            r_held_enc  <= '0;
            r_held_conv <= '0;
            r_held_busy <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_win_len <= i_cfg.data;
            end
            if (r_state == S_PUSH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (i_in.action) inside
                            ACT_LOSS: begin
                                r_res.frames_per_sec_x100 <= '0;
                                r_res.kilobits_per_sec    <= '0;
                                r_res.skips_per_sec_x100  <= '0;
                                r_res.encode_avg_us       <= r_held_enc;
                                r_res.convert_avg_us      <= r_held_conv;
                                r_res.busy_percent        <= r_held_busy;
                                r_res.window_closed       <= 1'b0;
                                r_state                   <= S_PUSH;
                            end
                            ACT_TICK: begin
                                if (acc.window_open) begin
                                    r_now   <= in_now;
                                    r_state <= S_ELAPSED;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_ELAPSED: begin
                    r_elapsed <= r_now - acc.start_time;
                    r_state   <= S_CMP;
                end
                S_CMP: begin
                    if (r_elapsed < TIME_WIDTH'(limit)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_sum   <= {1'b0, acc.enc_total} + {1'b0, acc.conv_total};
                        r_op    <= OP_FPS;
                        r_state <= S_LAUNCH;
                    end
                end
                S_LAUNCH, S_WAIT: begin
                    if (op_fin) begin
                        unique case (r_op)
                            OP_FPS:  r_res.frames_per_sec_x100 <= op_val;
                            OP_KBPS: r_res.kilobits_per_sec    <= op_val;
                            OP_SPS:  r_res.skips_per_sec_x100  <= op_val;
                            OP_ENC:  r_res.encode_avg_us       <= op_val;
                            OP_CONV: r_res.convert_avg_us      <= op_val;
                            OP_BUSY: r_res.busy_percent        <= op_val[BUSY_W-1:0];
                            default: begin
                            end
                        endcase
                        if (r_op == OP_BUSY) begin
                            r_state <= S_CLOSE;
                        end else begin
                            r_op    <= t_op'(r_op + 3'd1);
                            r_state <= S_LAUNCH;
                        end
                    end else if (r_state == S_LAUNCH) begin
                        r_state <= S_WAIT;
                    end
                end
                S_CLOSE: begin
                    r_held_enc          <= r_res.encode_avg_us;
                    r_held_conv         <= r_res.convert_avg_us;
                    r_held_busy         <= r_res.busy_percent;
                    r_res.window_closed <= 1'b1;
                    r_state             <= S_PUSH;
                end
                S_PUSH: begin
                    if (out_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid               = r_out_valid;
    assign o_out.frames_per_sec_x100 = r_out.frames_per_sec_x100;
    assign o_out.kilobits_per_sec    = r_out.kilobits_per_sec;
    assign o_out.skips_per_sec_x100  = r_out.skips_per_sec_x100;
    assign o_out.encode_avg_us       = r_out.encode_avg_us;
    assign o_out.convert_avg_us      = r_out.convert_avg_us;
    assign o_out.busy_percent        = r_out.busy_percent;
    assign o_out.window_closed       = r_out.window_closed;

    `WRM_ASSERT_NOW(a_quotient_when_waiting, md_rsp.done, r_state == S_WAIT, "stray quotient")
    `WRM_ASSERT_NEXT(a_close_clears, r_state == S_CLOSE,
                     acc.frame_count == '0 && acc.enc_count == '0 && acc.byte_total == '0,
                     "accumulators not cleared on window close")
    `WRM_ASSERT_NEXT(a_push_loads, r_state == S_PUSH && out_free,
                     r_out_valid && r_state == S_IDLE,
                     "result not moved to the output register")

endmodule
